// ----- rtl/mmsr_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants of the matrix min/max/sum reduction
package mmsr_pkg;

	// fixed field widths
	localparam int ELEM_W   = 32;
	localparam int COORD_W  = 12;
	localparam int CFG_W    = 13;
	localparam int RES_W    = 3 * ELEM_W + 4 * COORD_W + 1;
	localparam int OUT_W    = ((RES_W + 7) / 8) * 8;

	// default bounds on matrix shape
	localparam int MAX_COLS_DEF = 4096;
	localparam int MAX_ROWS_DEF = 4096;

	// queue between the front and back parts
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// one classified element as it travels from front to back
	typedef struct packed {
		logic [ELEM_W-1:0]  value;
		logic               last;
		logic               first;
		logic               ovf;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} item_t;

	// one finished reduction
	typedef struct packed {
		logic [ELEM_W-1:0]  total_sum;
		logic [ELEM_W-1:0]  min_value;
		logic [ELEM_W-1:0]  max_value;
		logic [COORD_W-1:0] min_row;
		logic [COORD_W-1:0] min_col;
		logic [COORD_W-1:0] max_row;
		logic [COORD_W-1:0] max_col;
		logic               row_overflow;
	} result_t;

	// status of the queue seen by its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- rtl/matrix_min_max_sum_reduction.sv -----
`timescale 1ns / 1ps
// top level of the streaming matrix sum, min and max reduction
//
//  channel   direction  signals                                  carries
//  s_axis    in         s_axis_tvalid/tready/tdata/tlast         element, last flag
//  m_axis    out        m_axis_tvalid/tready/tdata               one result per matrix
//  cfg       in         cfg_valid/cfg_ready/cfg_data             column count
//
//  one element is taken every cycle while the queue is not full; the front tags it
//  with its row and column and a four-entry queue hands it to the back, which updates
//  sum, min and max. the last element passes through the queue and then the result
//  register before its result is shown. reset clears the counters, the queue and the
//  result valid flag; num_cols is 1. a stalled result holds the back only on the next
//  last element; the queue absorbs up to four elements before s_axis_tready drops.
module matrix_min_max_sum_reduction #(
	parameter int MAX_COLS = mmsr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = mmsr_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// element_value[31:0]
	input  logic [mmsr_pkg::ELEM_W-1:0]  s_axis_tdata,
	// last_element
	input  logic                         s_axis_tlast,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// total_sum[31:0], min_value[63:32], max_value[95:64], min_row[107:96],
	// min_col[119:108], max_row[131:120], max_col[143:132], row_overflow[144]
	output logic [mmsr_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mmsr_pkg::CFG_W-1:0]   cfg_data
);
	import mmsr_pkg::*;

	logic    push;
	logic    pop;
	item_t   wr_item;
	item_t   head;
	qstat_t  qstat;
	result_t res;

	assign cfg_ready = 1'b1;

	// tag incoming elements
	mmsr_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.qstat     (qstat),
		.push      (push),
		.item      (wr_item)
	);

	// decoupling queue
	mmsr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (head),
		.qstat   (qstat)
	);

	// reductions and result register
	mmsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res       (res),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready)
	);

	// pack the result, first field lowest
	assign m_axis_tdata = OUT_W'({res.row_overflow, res.max_col, res.max_row,
		res.min_col, res.min_row, res.max_value, res.min_value, res.total_sum});

endmodule

// ----- rtl/mmsr_front.sv -----
`timescale 1ns / 1ps
// front part: column count register, coordinate counters and item tagging
module mmsr_front #(
	parameter int MAX_COLS = mmsr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = mmsr_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mmsr_pkg::ELEM_W-1:0]  in_value,
	input  logic                         in_last,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cfg_valid,
	input  logic [mmsr_pkg::CFG_W-1:0]   cfg_data,
	input  mmsr_pkg::qstat_t             qstat,
	output logic                         push,
	output mmsr_pkg::item_t              item
);
	import mmsr_pkg::*;

	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;
	localparam int RXW  = RW + 1;
	localparam int CXW  = (CW > COORD_W) ? CW : COORD_W;
	localparam int RYW  = (RW > COORD_W) ? RW : COORD_W;

	logic [CFG_W-1:0] eff_cols_q;
	logic [CW-1:0]    col_q;
	logic [RW-1:0]    row_q;
	logic             first_q;
	logic             ovf_q;
	logic             col_wrap;
	logic             row_full;
	logic             accept;
	logic [CXW-1:0]   col_x;
	logic [RYW-1:0]   row_x;

	// column count, clamped to the supported range on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_cols_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				eff_cols_q <= CFG_W'(1);
			end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
				eff_cols_q <= CFG_W'(MAX_COLS);
			end else begin
				eff_cols_q <= cfg_data;
			end
		end
	end

	// handshake into the queue
	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;

	// wrap conditions
	assign col_wrap = (CMPW'(col_q) + CMPW'(1)) >= CMPW'(eff_cols_q);
	assign row_full = (RXW'(row_q) + RXW'(1)) >= RXW'(MAX_ROWS);

	// coordinate counters, cleared after the last element of a matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			first_q <= 1'b1;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				col_q   <= '0;
				row_q   <= '0;
				first_q <= 1'b1;
				ovf_q   <= 1'b0;
			end else begin
				first_q <= 1'b0;
				if (col_wrap) begin
					col_q <= '0;
					if (row_full) begin
						ovf_q <= 1'b1;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end

	// tag the element with its position and matrix markers
	assign col_x = CXW'(col_q);
	assign row_x = RYW'(row_q);

	always_comb begin
		item.value = in_value;
		item.last  = in_last;
		item.first = first_q;
		item.ovf   = ovf_q;
		item.row   = row_x[COORD_W-1:0];
		item.col   = col_x[COORD_W-1:0];
	end

endmodule

// ----- rtl/mmsr_queue.sv -----
`timescale 1ns / 1ps
// short item queue between the front and back parts
module mmsr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mmsr_pkg::item_t   wr_item,
	input  logic              pop,
	output mmsr_pkg::item_t   rd_item,
	output mmsr_pkg::qstat_t  qstat
);
	import mmsr_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	// status
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_item     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/mmsr_back.sv -----
`timescale 1ns / 1ps
// back part: running sum, min/max tracking and result register
module mmsr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mmsr_pkg::item_t   head,
	input  mmsr_pkg::qstat_t  qstat,
	output logic              pop,
	output mmsr_pkg::result_t res,
	output logic              res_valid,
	input  logic              res_ready
);
	import mmsr_pkg::*;

	logic [ELEM_W-1:0]  sum_q;
	logic [ELEM_W-1:0]  low_q;
	logic [ELEM_W-1:0]  high_q;
	logic [COORD_W-1:0] low_row_q;
	logic [COORD_W-1:0] low_col_q;
	logic [COORD_W-1:0] high_row_q;
	logic [COORD_W-1:0] high_col_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               out_free;
	logic               take_low;
	logic               take_high;
	logic [ELEM_W-1:0]  sum_nxt;
	logic [ELEM_W-1:0]  low_nxt;
	logic [ELEM_W-1:0]  high_nxt;
	logic [COORD_W-1:0] low_row_nxt;
	logic [COORD_W-1:0] low_col_nxt;
	logic [COORD_W-1:0] high_row_nxt;
	logic [COORD_W-1:0] high_col_nxt;

	// a last item needs a free result slot, any other item goes straight in
	assign out_free = !out_valid_q || res_ready;
	assign pop      = !qstat.empty && (!head.last || out_free);

	// strict compares keep the first occurrence
	assign take_low  = head.first || ($signed(head.value) < $signed(low_q));
	assign take_high = head.first || ($signed(head.value) > $signed(high_q));

	always_comb begin
		sum_nxt      = head.first ? head.value : sum_q + head.value;
		low_nxt      = take_low ? head.value : low_q;
		low_row_nxt  = take_low ? head.row : low_row_q;
		low_col_nxt  = take_low ? head.col : low_col_q;
		high_nxt     = take_high ? head.value : high_q;
		high_row_nxt = take_high ? head.row : high_row_q;
		high_col_nxt = take_high ? head.col : high_col_q;
	end

	// running reductions
	always_ff @(posedge clk) begin
		if (pop) begin
			sum_q      <= sum_nxt;
			low_q      <= low_nxt;
			low_row_q  <= low_row_nxt;
			low_col_q  <= low_col_nxt;
			high_q     <= high_nxt;
			high_row_q <= high_row_nxt;
			high_col_q <= high_col_nxt;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_q.total_sum    <= sum_nxt;
			out_q.min_value    <= low_nxt;
			out_q.max_value    <= high_nxt;
			out_q.min_row      <= low_row_nxt;
			out_q.min_col      <= low_col_nxt;
			out_q.max_row      <= high_row_nxt;
			out_q.max_col      <= high_col_nxt;
			out_q.row_overflow <= head.ovf;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && head.last) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res       = out_q;
	assign res_valid = out_valid_q;

endmodule

// ----- rtl/mmsr_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the matrix reduction, bound to the top level
module mmsr_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_axis_tvalid,
	input logic                         s_axis_tready,
	input logic                         s_axis_tlast,
	input logic                         m_axis_tvalid,
	input logic                         m_axis_tready,
	input logic [mmsr_pkg::OUT_W-1:0]   m_axis_tdata
);
	import mmsr_pkg::*;

	localparam int PEND_W = $clog2(QUEUE_DEPTH + 2) + 1;

	logic [PEND_W-1:0] pend_q;
	logic              last_in;
	logic              res_out;

	assign last_in = s_axis_tvalid && s_axis_tready && s_axis_tlast;
	assign res_out = m_axis_tvalid && m_axis_tready;

	// matrices taken but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_in, res_out})
				2'b10:   pend_q <= pend_q + PEND_W'(1);
				2'b01:   pend_q <= pend_q - PEND_W'(1);
				default: pend_q <= pend_q;
			endcase
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a result only follows a last element
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != '0)
		else $error("result without a finished matrix");

	// back pressure bounds the matrices in flight
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= PEND_W'(QUEUE_DEPTH + 1))
		else $error("too many matrices in flight");

	// minimum never exceeds maximum
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $signed(m_axis_tdata[2*ELEM_W-1:ELEM_W])
			<= $signed(m_axis_tdata[3*ELEM_W-1:2*ELEM_W]))
		else $error("min above max");

endmodule

bind matrix_min_max_sum_reduction mmsr_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ----- bench/reduction_checker.sv -----
`timescale 1ns / 1ps
// checker that predicts each matrix reduction and compares it with the block's results
module reduction_checker #(
	parameter int MAX_COLS = mmsr_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = mmsr_pkg::MAX_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	input  logic                         s_axis_tready,
	// element_value[31:0]
	input  logic [mmsr_pkg::ELEM_W-1:0]  s_axis_tdata,
	// last_element
	input  logic                         s_axis_tlast,
	input  logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// total_sum[31:0], min_value[63:32], max_value[95:64], min_row[107:96],
	// min_col[119:108], max_row[131:120], max_col[143:132], row_overflow[144]
	input  logic [mmsr_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [mmsr_pkg::CFG_W-1:0]   cfg_data,
	output int                           fail_count,
	output int                           pending
);
	import mmsr_pkg::*;

	// bit offsets of the result fields in m_axis_tdata
	localparam int SUM_AT  = 0;
	localparam int MIN_AT  = ELEM_W;
	localparam int MAX_AT  = 2 * ELEM_W;
	localparam int LROW_AT = 3 * ELEM_W;
	localparam int LCOL_AT = LROW_AT + COORD_W;
	localparam int HROW_AT = LCOL_AT + COORD_W;
	localparam int HCOL_AT = HROW_AT + COORD_W;
	localparam int OVF_AT  = HCOL_AT + COORD_W;

	typedef struct {
		logic [ELEM_W-1:0]        total_sum;
		logic signed [ELEM_W-1:0] min_value;
		logic signed [ELEM_W-1:0] max_value;
		logic [COORD_W-1:0]       min_row;
		logic [COORD_W-1:0]       min_col;
		logic [COORD_W-1:0]       max_row;
		logic [COORD_W-1:0]       max_col;
		logic                     row_overflow;
	} reduction_t;

	// mirrored column setting and per-matrix accumulation
	logic [CFG_W-1:0]         col_setting;
	logic [ELEM_W-1:0]        sum_acc;
	logic signed [ELEM_W-1:0] low_val;
	logic signed [ELEM_W-1:0] high_val;
	logic [COORD_W-1:0]       low_row, low_col, high_row, high_col;
	logic [COORD_W-1:0]       col_at, row_at;
	bit                       fresh;
	bit                       rows_spilled;
	reduction_t               reductions_due[$];

	initial fail_count = 0;

	function automatic void clear_matrix_state();
		sum_acc      = '0;
		low_val      = '0;
		high_val     = '0;
		low_row      = '0;
		low_col      = '0;
		high_row     = '0;
		high_col     = '0;
		col_at       = '0;
		row_at       = '0;
		fresh        = 1'b1;
		rows_spilled = 1'b0;
	endfunction

	// a zero setting means one column, anything past the bound is clamped
	function automatic int active_cols();
		if (col_setting == 0)
			return 1;
		if (col_setting > MAX_COLS)
			return MAX_COLS;
		return int'(col_setting);
	endfunction

	// fold one element into the running matrix; returns 1 with the reduction on the last one
	function automatic bit fold_element(input logic signed [ELEM_W-1:0] v, input logic last,
			output reduction_t r);
		r = '{default: '0};
		sum_acc = sum_acc + v;
		if (fresh) begin
			low_val  = v;
			high_val = v;
			low_row  = row_at;
			low_col  = col_at;
			high_row = row_at;
			high_col = col_at;
			fresh    = 1'b0;
		end else begin
			// strict compares keep the first occurrence on ties
			if (v < low_val) begin
				low_val = v;
				low_row = row_at;
				low_col = col_at;
			end
			if (v > high_val) begin
				high_val = v;
				high_row = row_at;
				high_col = col_at;
			end
		end
		if (last) begin
			r.total_sum    = sum_acc;
			r.min_value    = low_val;
			r.max_value    = high_val;
			r.min_row      = low_row;
			r.min_col      = low_col;
			r.max_row      = high_row;
			r.max_col      = high_col;
			r.row_overflow = rows_spilled;
			clear_matrix_state();
			return 1'b1;
		end
		// column wrap steps the row, which sticks at the last row on overflow
		if (int'(col_at) + 1 >= active_cols()) begin
			col_at = '0;
			if (int'(row_at) + 1 >= MAX_ROWS)
				rows_spilled = 1'b1;
			else
				row_at = row_at + 1'b1;
		end else begin
			col_at = col_at + 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [ELEM_W-1:0] want,
			input logic [ELEM_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// watch all three channels on each rising edge
	always @(posedge clk or negedge arst_n) begin : watch
		reduction_t want;
		reduction_t fresh_result;
		if (!arst_n) begin
			col_setting = CFG_W'(1);
			clear_matrix_state();
			reductions_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				col_setting = cfg_data;
			// compare first: a result never belongs to an element taken at the same edge
			if (m_axis_tvalid && m_axis_tready) begin
				if (reductions_due.size() == 0) begin
					$error("result item with no reduction pending");
					fail_count++;
				end else begin
					want = reductions_due.pop_front();
					check_field("total_sum", want.total_sum, m_axis_tdata[SUM_AT +: ELEM_W]);
					check_field("min_value", want.min_value, m_axis_tdata[MIN_AT +: ELEM_W]);
					check_field("max_value", want.max_value, m_axis_tdata[MAX_AT +: ELEM_W]);
					check_field("min_row", want.min_row, m_axis_tdata[LROW_AT +: COORD_W]);
					check_field("min_col", want.min_col, m_axis_tdata[LCOL_AT +: COORD_W]);
					check_field("max_row", want.max_row, m_axis_tdata[HROW_AT +: COORD_W]);
					check_field("max_col", want.max_col, m_axis_tdata[HCOL_AT +: COORD_W]);
					check_field("row_overflow", want.row_overflow, m_axis_tdata[OVF_AT]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (fold_element(s_axis_tdata, s_axis_tlast, fresh_result))
					reductions_due.insert(reductions_due.size(), fresh_result);
			end
			pending = reductions_due.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// top of the bench: clock, reset, element and column stimulus, result sink and verdict
module testbench;
	import mmsr_pkg::*;

	typedef enum int {VALS_FULL, VALS_NARROW, VALS_EXTREME} value_mix_t;

	localparam int RANDOM_ITEMS = 630;
	localparam int HOLD_CYCLES  = 300;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// element_value[31:0]
	logic [ELEM_W-1:0] s_axis_tdata = '0;
	// last_element
	logic              s_axis_tlast = 1'b0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// total_sum[31:0], min_value[63:32], max_value[95:64], min_row[107:96],
	// min_col[119:108], max_row[131:120], max_col[143:132], row_overflow[144]
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_data = '0;

	int fail_count;
	int pending;
	bit calm_mode = 1'b0;
	int hold_asked = 0;
	int elements_sent = 0;

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	matrix_min_max_sum_reduction dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	reduction_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// hard stop well past the slowest correct run
	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// result sink: random back-pressure, plus a long hold-off when asked
	initial begin : result_sink
		int hold_left;
		int holds_served;
		hold_left = 0;
		holds_served = 0;
		forever begin
			@(negedge clk);
			if (holds_served != hold_asked) begin
				holds_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm_mode || ($urandom_range(99) >= 38);
			end
		end
	end

	// offer one element with random gaps ahead of it, return after it is taken
	task automatic drive_element(input logic [ELEM_W-1:0] v, input logic last);
		while (!calm_mode && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		elements_sent++;
	endtask

	// column count changes only once the block has drained
	task automatic write_cols(input logic [CFG_W-1:0] cols);
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ELEM_W-1:0] pick_value(input value_mix_t mix);
		logic [ELEM_W-1:0] corner [5];
		corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1};
		case (mix)
			VALS_NARROW:  return ELEM_W'($urandom_range(6)) - ELEM_W'(3);
			VALS_EXTREME: return corner[$urandom_range(4)];
			default:      return $urandom();
		endcase
	endfunction

	// zero, one, the bound, all ones and in-between column counts
	function automatic logic [CFG_W-1:0] pick_cols();
		case ($urandom_range(7))
			0:       return '0;
			1:       return CFG_W'(1);
			2:       return CFG_W'(MAX_COLS_DEF);
			3:       return '1;
			4:       return CFG_W'($urandom_range(8191));
			default: return CFG_W'($urandom_range(2, 9));
		endcase
	endfunction

	task automatic send_matrix(input int n, input value_mix_t mix);
		for (int i = 0; i < n; i++)
			drive_element(pick_value(mix), i == n - 1);
	endtask

	// stimulus
	initial begin : stimulus
		int random_goal;
		int matrices;
		matrices = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single element: min and max at row 0, column 0
		drive_element(32'h8000_0000, 1'b1);

		// extremes, ties at both ends and a wrapping sum over three columns
		write_cols(CFG_W'(3));
		drive_element(32'h7FFF_FFFF, 1'b0);
		drive_element(32'h8000_0000, 1'b0);
		drive_element(32'h0000_0005, 1'b0);
		drive_element(32'h8000_0000, 1'b0);
		drive_element(32'h7FFF_FFFF, 1'b0);
		drive_element(32'hFFFF_FFFF, 1'b1);

		// zero column count behaves as one column
		write_cols('0);
		drive_element(32'h0000_0001, 1'b0);
		drive_element(32'h0000_0001, 1'b0);
		drive_element(32'h0000_0000, 1'b1);

		// oversized column count clamps to the bound
		write_cols('1);
		drive_element(32'hFFFF_FFFB, 1'b0);
		drive_element(32'h0000_0003, 1'b0);
		drive_element(32'hFFFF_FFFB, 1'b0);
		drive_element(32'h0000_0003, 1'b1);

		// all elements equal: first position wins both ways
		write_cols(CFG_W'(2));
		for (int i = 0; i < 5; i++)
			drive_element(32'h0000_0007, i == 4);

		// random matrices, mostly small, with calm stretch and a long hold-off
		random_goal = elements_sent + RANDOM_ITEMS;
		while (elements_sent < random_goal) begin
			matrices++;
			if ($urandom_range(4) == 0)
				write_cols(pick_cols());
			calm_mode = (matrices >= 20 && matrices < 30);
			if (matrices == 12) begin
				// many short matrices while results are blocked fill the queue
				hold_asked++;
				repeat (16) send_matrix($urandom_range(1, 3), value_mix_t'($urandom_range(2)));
			end
			send_matrix($urandom_range(1, 24), value_mix_t'($urandom_range(2)));
		end
		calm_mode = 1'b0;

		// drain, then allow stray results to show up
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (16) @(negedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/mmsr_pkg.sv
rtl/mmsr_front.sv
rtl/mmsr_queue.sv
rtl/mmsr_back.sv
rtl/matrix_min_max_sum_reduction.sv
rtl/mmsr_checker.sv
bench/reduction_checker.sv
bench/testbench.sv
